### src/itp_pkg.sv
// Shared types, codes and lookup functions for the infix to postfix converter.
`default_nettype none

package itp_pkg;

  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam int unsigned RES_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_POW    = 8'h5E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_OPEN = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5,
    OP_POW  = 3'd6
  } op_code_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNMATCHED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_OPERAND,
    CMD_OPEN,
    CMD_CLOSE,
    CMD_OPER,
    CMD_FLUSH
  } cmd_kind_e;

  typedef enum logic {
    ACT_CHAR = 1'b0,
    ACT_END  = 1'b1
  } action_e;

  typedef struct packed {
    logic       action;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] ch;
    op_code_e   op;
  } cmd_t;

  function automatic logic [1:0] op_prec(op_code_e op);
    logic [1:0] prec;
    unique case (op)
      OP_ADD, OP_SUB: prec = 2'd1;
      OP_MUL, OP_DIV: prec = 2'd2;
      OP_POW:         prec = 2'd3;
      default:        prec = 2'd0;
    endcase
    return prec;
  endfunction

  function automatic logic [7:0] op_char(op_code_e op);
    logic [7:0] c;
    unique case (op)
      OP_OPEN: c = CH_LPAREN;
      OP_ADD:  c = CH_ADD;
      OP_SUB:  c = CH_SUB;
      OP_MUL:  c = CH_MUL;
      OP_DIV:  c = CH_DIV;
      OP_POW:  c = CH_POW;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### src/infix_to_postfix_converter.sv
// Top level of the infix to postfix converter.
`default_nettype none

// Converts an infix expression, one ASCII character per transaction, to
// postfix with an operator stack of STACK_DEPTH entries (shunting-yard, all
// operators left-associative). Letters and digits come out at once; operators
// and parentheses go through the stack; an end transaction flushes it. Other
// characters produce nothing. Each result carries last on the final symbol
// caused by its input, and a status for stack overflow or a stray closing
// parenthesis. Input transactions are classified and queued in a two-entry
// command queue; the stack engine behind it handles one stack pop or push per
// cycle while a command waits and the result queue has room. An operator pops
// each stacked operator of equal or higher precedence, then is pushed. A
// closing parenthesis pops entries up to its matching opening parenthesis; an
// end pops every entry. A letter, a digit or an opening parenthesis needs no
// pop. Results leave through a two-entry queue at up to one per cycle.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire itp_pkg::in_item_t item_i,
  output logic                   empty,
  input  wire logic              pop,
  output itp_pkg::result_t       result_o
);

  import itp_pkg::*;

  logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t    cmd_in, cmd_head;
  logic    res_push, res_full;
  result_t res_in;

  itp_front u_front (
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  itp_fifo #(
    .item_t (cmd_t),
    .DEPTH  (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  itp_fifo #(
    .item_t (result_t),
    .DEPTH  (RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

### src/itp_fifo.sv
// Small synchronous queue used between the converter's stages.
`default_nettype none

module itp_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output item_t      data_o,
  output logic       empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### src/itp_front.sv
// Front end: accepts infix characters and turns them into stack commands.
`default_nettype none

module itp_front (
  input  wire logic            push_i,
  input  wire itp_pkg::in_item_t item_i,
  output logic                 full_o,
  input  wire logic            cmd_full_i,
  output logic                 cmd_push_o,
  output itp_pkg::cmd_t        cmd_o
);

  import itp_pkg::*;

  logic keep;
  logic is_operand;

  assign is_operand = ((item_i.ch >= 8'h30) && (item_i.ch <= 8'h39)) ||
                      ((item_i.ch >= 8'h41) && (item_i.ch <= 8'h5A)) ||
                      ((item_i.ch >= 8'h61) && (item_i.ch <= 8'h7A));

  always_comb begin
    keep      = 1'b1;
    cmd_o.ch  = item_i.ch;
    cmd_o.op  = OP_NONE;
    cmd_o.kind = CMD_OPERAND;
    priority if (item_i.action == ACT_END) begin
      cmd_o.kind = CMD_FLUSH;
    end else if (item_i.ch == CH_RPAREN) begin
      cmd_o.kind = CMD_CLOSE;
    end else if (is_operand) begin
      cmd_o.kind = CMD_OPERAND;
    end else if (item_i.ch == CH_LPAREN) begin
      cmd_o.kind = CMD_OPEN;
      cmd_o.op   = OP_OPEN;
    end else begin
      cmd_o.kind = CMD_OPER;
      unique case (item_i.ch)
        CH_ADD:  cmd_o.op = OP_ADD;
        CH_SUB:  cmd_o.op = OP_SUB;
        CH_MUL:  cmd_o.op = OP_MUL;
        CH_DIV:  cmd_o.op = OP_DIV;
        CH_POW:  cmd_o.op = OP_POW;
        default: keep = 1'b0;
      endcase
    end
  end

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i && !cmd_full_i && keep;

endmodule

`default_nettype wire

### src/itp_back.sv
// Back end: runs stack commands against the operator stack and emits results.
`default_nettype none

module itp_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_empty_i,
  input  wire itp_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output itp_pkg::result_t   res_o
);

  import itp_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  op_code_e      stack_mem [STACK_DEPTH];
  op_code_e      top_q, nxt_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] count_m3;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          do_pop, do_push, push_req, one_left, stack_full, pop_ok, cont;
  op_code_e      push_code;
  logic [1:0]    prec;

  assign stack_full = (count_q == CW'(STACK_DEPTH));
  assign one_left   = (count_q == CW'(1));
  assign count_m3   = count_q - CW'(3);
  assign wr_addr    = count_q[AW-1:0];
  assign rd_addr    = count_m3[AW-1:0];
  assign prec       = op_prec(cmd_i.op);
  assign pop_ok     = (count_q != '0) && (top_q != OP_OPEN) && (op_prec(top_q) >= prec);
  assign cont       = !one_left && (nxt_q != OP_OPEN) && (op_prec(nxt_q) >= prec);

  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    push_req   = 1'b0;
    push_code  = cmd_i.op;
    if (!cmd_empty_i && !res_full_i) begin
      unique case (cmd_i.kind)
        CMD_OPERAND: begin
          res_push_o = 1'b1;
          res_o      = '{symbol: cmd_i.ch, last: 1'b1, status: ST_OK};
          cmd_pop_o  = 1'b1;
        end
        CMD_OPEN: begin
          push_req  = 1'b1;
          cmd_pop_o = 1'b1;
        end
        CMD_FLUSH: begin
          if (count_q == '0) begin
            cmd_pop_o = 1'b1;
          end else begin
            do_pop     = 1'b1;
            res_push_o = 1'b1;
            res_o      = '{symbol: op_char(top_q), last: one_left, status: ST_OK};
            cmd_pop_o  = one_left;
          end
        end
        CMD_CLOSE: begin
          if (count_q == '0) begin
            res_push_o = 1'b1;
            res_o      = '{symbol: CH_NUL, last: 1'b1, status: ST_UNMATCHED};
            cmd_pop_o  = 1'b1;
          end else if (top_q == OP_OPEN) begin
            do_pop    = 1'b1;
            cmd_pop_o = 1'b1;
          end else begin
            do_pop       = 1'b1;
            res_push_o   = 1'b1;
            res_o.symbol = op_char(top_q);
            res_o.last   = one_left || (nxt_q == OP_OPEN);
            res_o.status = one_left ? ST_UNMATCHED : ST_OK;
            cmd_pop_o    = one_left;
          end
        end
        CMD_OPER: begin
          if (pop_ok) begin
            do_pop     = 1'b1;
            res_push_o = 1'b1;
            res_o      = '{symbol: op_char(top_q), last: !cont, status: ST_OK};
          end else begin
            push_req  = 1'b1;
            cmd_pop_o = 1'b1;
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
      if (push_req) begin
        if (stack_full) begin
          res_push_o = 1'b1;
          res_o      = '{symbol: CH_NUL, last: 1'b1, status: ST_OVERFLOW};
        end else begin
          do_push = 1'b1;
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_push) begin
      count_d = count_q + CW'(1);
    end else if (do_pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // The top entry and the one beneath it are kept in registers so that a pop
  // can follow a pop in the next cycle.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      stack_mem[wr_addr] <= push_code;
      top_q              <= push_code;
      nxt_q              <= top_q;
    end else if (do_pop) begin
      top_q <= nxt_q;
      nxt_q <= stack_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
